FILE: rtl/core/spc_pkg.sv
package spc_pkg;

    localparam int unsigned PositionWidthDef = 16;
    localparam int unsigned TargetW          = 14;
    localparam int unsigned GainW            = 16;
    localparam int unsigned TimeW            = 32;
    localparam int unsigned LimitW           = 7;
    localparam int unsigned DutyW            = 7;
    localparam int unsigned PosOutW          = 16;
    localparam int unsigned AddrW            = 4;
    localparam int unsigned DataW            = 32;

    localparam int unsigned DutyMax          = 100;
    localparam int unsigned IntervalReset    = 10;

    // floor(x/5) = (x*205) >> 10, exact for x below 1024
    localparam int unsigned MagW             = 9;
    localparam int unsigned Div5Mul          = 205;
    localparam int unsigned Div5MulW         = 8;
    localparam int unsigned Div5Shift        = 10;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_TIME   = 1'b1
    } op_e;

    typedef enum logic [1:0]
    {
        REG_TARGET   = 2'd0,
        REG_GAIN     = 2'd1,
        REG_INTERVAL = 2'd2
    } reg_idx_e;

    typedef struct packed
    {
        logic signed [TargetW-1:0] target_position;
        logic [GainW-1:0]          proportional_gain;
        logic [TimeW-1:0]          update_interval;
        logic [LimitW-1:0]         error_limit;
    } cfg_t;

    // floor(100 / (gain + 1))
    function automatic logic [LimitW-1:0] error_limit_f(input logic [GainW-1:0] gain);
        logic [LimitW-1:0] lim;
        if (gain == GainW'(0))       lim = LimitW'(100);
        else if (gain == GainW'(1))  lim = LimitW'(50);
        else if (gain == GainW'(2))  lim = LimitW'(33);
        else if (gain == GainW'(3))  lim = LimitW'(25);
        else if (gain == GainW'(4))  lim = LimitW'(20);
        else if (gain == GainW'(5))  lim = LimitW'(16);
        else if (gain == GainW'(6))  lim = LimitW'(14);
        else if (gain == GainW'(7))  lim = LimitW'(12);
        else if (gain == GainW'(8))  lim = LimitW'(11);
        else if (gain == GainW'(9))  lim = LimitW'(10);
        else if (gain == GainW'(10)) lim = LimitW'(9);
        else if (gain == GainW'(11)) lim = LimitW'(8);
        else if (gain <= GainW'(13)) lim = LimitW'(7);
        else if (gain <= GainW'(15)) lim = LimitW'(6);
        else if (gain <= GainW'(19)) lim = LimitW'(5);
        else if (gain <= GainW'(24)) lim = LimitW'(4);
        else if (gain <= GainW'(32)) lim = LimitW'(3);
        else if (gain <= GainW'(49)) lim = LimitW'(2);
        else if (gain <= GainW'(99)) lim = LimitW'(1);
        else                         lim = LimitW'(0);
        return lim;
    endfunction

endpackage

FILE: rtl/core/spc_intf.sv
interface spc_sample_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic                        plus_line;
    logic                        minus_line;
    logic [spc_pkg::TimeW-1:0]   time_now;

    modport source (output valid, output operation, output plus_line, output minus_line,
                    output time_now, input ready);
    modport sink   (input valid, input operation, input plus_line, input minus_line,
                    input time_now, output ready);
endinterface

interface spc_result_if;
    logic                               valid;
    logic                               ready;
    logic                               drive_forward;
    logic [spc_pkg::DutyW-1:0]          duty;
    logic signed [spc_pkg::PosOutW-1:0] position_now;

    modport source (output valid, output drive_forward, output duty, output position_now,
                    input ready);
    modport sink   (input valid, input drive_forward, input duty, input position_now,
                    output ready);
endinterface

FILE: rtl/core/servo_position_p_controller_top.sv
// Servo position P controller.
// sample channel: one transaction per tachometer pin sample (operation 0, plus_line and
// minus_line) or per time stamp (operation 1, time_now). A rising plus_line counts the
// position up when minus_line is high, else down. A time stamp more than update_interval
// after the last update starts an update.
// result channel: one transaction per update with drive_forward, duty 0..100 and the
// position count used. Samples and time stamps that start no update give no result.
// APB port: registers target_position at 0x0, proportional_gain at 0x4 and
// update_interval at 0x8; pready is always high. Write only while no update is in flight.
// Throughput: one transaction per cycle on the sample channel while sample.ready is high. A
// result passes through four registers (input, error and saturation, gain product, result
// register fed by the divide by five).
// Reset: position, last update time and edge detector clear, update_interval returns to
// 10, gain and target to 0; no clearing pass.
// Stall: a held result back-fills the pipeline; sample.ready drops only once every
// stage holds an update, and samples stay accepted as long as any stage is free.
module servo_position_p_controller_top
#(
    parameter int unsigned PositionWidth = spc_pkg::PositionWidthDef
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    spc_sample_if.sink                  sample,
    spc_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spc_pkg::AddrW-1:0]   paddr,
    input  logic [spc_pkg::DataW-1:0]   pwdata,
    output logic [spc_pkg::DataW-1:0]   prdata,
    output logic                        pready
);
    import spc_pkg::*;

    cfg_t                     cfg;
    logic                     accept;
    logic                     start_ready;
    logic                     start_valid;
    logic [TimeW-1:0]         elapsed;
    logic                     armed_reg;
    logic                     armed_next;
    logic [PositionWidth-1:0] position_reg;
    logic [PositionWidth-1:0] position_next;
    logic [TimeW-1:0]         last_time_reg;
    logic [TimeW-1:0]         last_time_next;

    spc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign sample.ready = start_ready;
    assign accept       = sample.valid && start_ready;
    assign elapsed      = sample.time_now - last_time_reg;
    assign start_valid  = accept && (sample.operation == OP_TIME)
                          && (elapsed > cfg.update_interval);

    always_comb
    begin
        armed_next     = armed_reg;
        position_next  = position_reg;
        last_time_next = last_time_reg;
        if (accept && (sample.operation == OP_SAMPLE))
        begin
            if (!armed_reg && sample.plus_line)
            begin
                position_next = sample.minus_line ? position_reg + PositionWidth'(1)
                                                  : position_reg - PositionWidth'(1);
                armed_next    = 1'b1;
            end
            else if (armed_reg && !sample.plus_line)
            begin
                armed_next = 1'b0;
            end
        end
        if (start_valid)
        begin
            last_time_next = sample.time_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            position_reg  <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            armed_reg     <= armed_next;
            position_reg  <= position_next;
            last_time_reg <= last_time_next;
        end
    end

    spc_update #(.PositionWidth(PositionWidth)) u_update
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .start_valid (start_valid),
        .start_ready (start_ready),
        .start_pos   (position_reg),
        .result      (result)
    );

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((position_reg == $past(position_reg))
                  || (position_reg == $past(position_reg) + PositionWidth'(1))
                  || (position_reg == $past(position_reg) - PositionWidth'(1))))
        else $error("position moved by more than one count");

    a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !start_valid |=> $stable(last_time_reg))
        else $error("last update time changed without an update");

endmodule

FILE: rtl/core/spc_cfg.sv
module spc_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spc_pkg::AddrW-1:0]   paddr,
    input  logic [spc_pkg::DataW-1:0]   pwdata,
    output logic [spc_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output spc_pkg::cfg_t               cfg
);
    import spc_pkg::*;

    logic                      wr_en;
    reg_idx_e                  idx;
    logic signed [TargetW-1:0] target_reg;
    logic [GainW-1:0]          gain_reg;
    logic [TimeW-1:0]          interval_reg;
    logic [LimitW-1:0]         limit_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_e'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            gain_reg     <= '0;
            interval_reg <= TimeW'(IntervalReset);
            limit_reg    <= LimitW'(DutyMax);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TARGET:   target_reg   <= pwdata[TargetW-1:0];
                REG_GAIN:
                begin
                    gain_reg  <= pwdata[GainW-1:0];
                    limit_reg <= error_limit_f(pwdata[GainW-1:0]);
                end
                REG_INTERVAL: interval_reg <= pwdata[TimeW-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TARGET:   prdata = DataW'(unsigned'(target_reg));
            REG_GAIN:     prdata = DataW'(gain_reg);
            REG_INTERVAL: prdata = DataW'(interval_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.target_position   = target_reg;
    assign cfg.proportional_gain = gain_reg;
    assign cfg.update_interval   = interval_reg;
    assign cfg.error_limit       = limit_reg;

    a_limit_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(limit_reg) * (32'(gain_reg) + 32'd1)) <= 32'(DutyMax))
        else $error("error limit exceeds floor of 100/(gain+1)");

endmodule

FILE: rtl/core/spc_update.sv
module spc_update
#(
    parameter int unsigned PositionWidth = spc_pkg::PositionWidthDef
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  spc_pkg::cfg_t            cfg,
    input  logic                     start_valid,
    output logic                     start_ready,
    input  logic [PositionWidth-1:0] start_pos,
    spc_result_if.source             result
);
    import spc_pkg::*;

    localparam int unsigned EW   = ((PositionWidth > 17) ? PositionWidth : 17) + 1;
    localparam int unsigned ProdW = GainW + MagW;
    localparam int unsigned QW    = MagW + Div5MulW;

    logic                     s1_valid_reg;
    logic [PositionWidth-1:0] s1_pos_reg;
    logic                     s2_valid_reg;
    logic                     s2_sat_reg;
    logic                     s2_neg_reg;
    logic [MagW-1:0]          s2_mag_reg;
    logic [PosOutW-1:0]       s2_pos_reg;
    logic                     s3_valid_reg;
    logic                     s3_sat_reg;
    logic                     s3_neg_reg;
    logic [MagW-1:0]          s3_prod_reg;
    logic [PosOutW-1:0]       s3_pos_reg;
    logic                     o_valid_reg;
    logic                     o_fwd_reg;
    logic [DutyW-1:0]         o_duty_reg;
    logic [PosOutW-1:0]       o_pos_reg;

    logic                     o_ready;
    logic                     s3_ready;
    logic                     s2_ready;

    logic signed [EW-1:0]     tgt_ext;
    logic signed [EW-1:0]     pos_ext;
    logic signed [EW-1:0]     lim_ext;
    logic signed [EW-1:0]     e5;
    logic signed [EW-1:0]     lim5;
    logic [EW-1:0]            mag_full;
    logic                     sat;
    logic                     neg;
    logic [ProdW-1:0]         prod_full;
    logic [QW-1:0]            q_full;
    logic [DutyW-1:0]         quot;

    assign o_ready     = !o_valid_reg || result.ready;
    assign s3_ready    = !s3_valid_reg || o_ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign start_ready = !s1_valid_reg || s2_ready;

    // error in fifths of a count and saturation decision
    always_comb
    begin
        tgt_ext  = EW'(cfg.target_position);
        pos_ext  = EW'(signed'(s1_pos_reg));
        lim_ext  = EW'(signed'({1'b0, cfg.error_limit}));
        e5       = (tgt_ext <<< 2) + tgt_ext - pos_ext;
        lim5     = (lim_ext <<< 2) + lim_ext;
        sat      = (e5 > lim5) || (e5 < -lim5);
        neg      = e5[EW-1];
        mag_full = neg ? unsigned'(-e5) : unsigned'(e5);
    end

    assign prod_full = ProdW'(cfg.proportional_gain) * ProdW'(s2_mag_reg);
    assign q_full    = QW'(s3_prod_reg) * QW'(Div5Mul);
    assign quot      = q_full[Div5Shift+DutyW-1:Div5Shift];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (start_ready)
            begin
                s1_valid_reg <= start_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_ready && start_valid)
        begin
            s1_pos_reg <= start_pos;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_sat_reg <= sat;
            s2_neg_reg <= neg;
            s2_mag_reg <= mag_full[MagW-1:0];
            s2_pos_reg <= PosOutW'(s1_pos_reg);
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_sat_reg  <= s2_sat_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_prod_reg <= prod_full[MagW-1:0];
            s3_pos_reg  <= s2_pos_reg;
        end
        if (o_ready && s3_valid_reg)
        begin
            o_fwd_reg  <= !s3_neg_reg && (s3_sat_reg || (quot != '0));
            o_duty_reg <= s3_sat_reg ? DutyW'(DutyMax) : quot;
            o_pos_reg  <= s3_pos_reg;
        end
    end

    assign result.valid         = o_valid_reg;
    assign result.drive_forward = o_fwd_reg;
    assign result.duty          = o_duty_reg;
    assign result.position_now  = signed'(o_pos_reg);

    a_prod_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_sat_reg) |-> (prod_full < ProdW'(5 * DutyMax)))
        else $error("unsaturated product out of range");

    a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (o_duty_reg <= DutyW'(DutyMax)))
        else $error("duty above maximum");

endmodule
